// File: design/fsme_pkg.sv
// Shared codes and constants of the table-driven state machine engine.
`timescale 1ns / 1ps
`default_nettype none

package fsme_pkg;

  // Operation selector carried in the input tuser
  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_EVENT = 2'd1,
    FN_LIST  = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_MATCH = 2'd1,
    STS_FULL     = 2'd2
  } status_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_STATE = 1'b0,
    REG_FINAL_MASK = 1'b1
  } reg_idx_t;

  // Fixed port field widths
  localparam int STATE_FIELD_W = 6;
  localparam int EVENT_FIELD_W = 8;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 16;
  localparam int OUT_USER_W    = 3;

  // Sequencer states
  typedef enum logic [2:0] {
    SQ_IDLE = 3'b001,
    SQ_SCAN = 3'b010,
    SQ_FIN  = 3'b100
  } seq_state_t;

endpackage

`default_nettype wire

// File: design/table_driven_fsm_engine.sv
// Top level of the table-driven state machine engine.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  in_      | slave     | tvalid/tready        | tuser func, tdata edge and event fields
//  out_     | master    | tvalid/tready, tlast | tuser status/next_valid, tdata state
//  cfg_     | write     | cfg_we               | cfg_index, cfg_wdata (64 bits)
//
// Add and clear requests go straight from idle to the result state. Event and list
// requests scan the table: the sequencer reads the edge memory one entry a cycle,
// except while a list scan pauses, through its single registered read port, and
// then loads the result. An event request that hits ends its scan at the matching edge.
// Reset is synchronous and clears the edge count, present state and configuration registers.
// A stalled output holds its result; a list scan pauses while a listed event
// cannot be passed on.
`timescale 1ns / 1ps
`default_nettype none

module table_driven_fsm_engine #(
  parameter int TABLE_DEPTH = 32,
  parameter int STATE_BITS  = 6,
  parameter int EVENT_BITS  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [5:0] edge_from, [13:6] edge_event, [19:14] edge_next, [27:20] event_id
  input  wire logic [fsme_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] func
  input  wire logic [1:0]                       in_tuser,
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [5:0] state_out, [6] in_final, [7] init_is_final, [15:8] next_event
  output logic      [fsme_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status, [2] next_valid
  output logic      [fsme_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                                  out_tlast,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [fsme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fsme_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import fsme_pkg::*;

  localparam int SB    = STATE_BITS;
  localparam int EB    = EVENT_BITS;
  localparam int ENT_W = 2 * SB + EB;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);

  // Registers
  seq_state_t             sq_r, sq_nxt;
  logic [STATE_FIELD_W-1:0] init_r;
  logic [63:0]            mask_r;
  logic [SB-1:0]          ps_r, ps_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          addr_r, addr_nxt;
  logic                   rdv_r, rdv_nxt;
  logic                   list_r, list_nxt;
  logic [EB-1:0]          eid_r, eid_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [EB-1:0]          pend_r, pend_nxt;
  status_t                fin_sts_r, fin_sts_nxt;
  logic [EB-1:0]          fin_evt_r, fin_evt_nxt;
  logic                   fin_nv_r, fin_nv_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_sts_r, out_sts_nxt;
  logic [STATE_FIELD_W-1:0] out_state_r, out_state_nxt;
  logic                   out_fin_r, out_fin_nxt;
  logic                   out_ifin_r, out_ifin_nxt;
  logic [EVENT_FIELD_W-1:0] out_evt_r, out_evt_nxt;
  logic                   out_nv_r, out_nv_nxt;
  logic                   out_last_r, out_last_nxt;

  // Memory port signals
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ENT_W-1:0]       wr_data;
  logic                   rd_en;
  logic [ENT_W-1:0]       rd_data;

  // Request fields, cut or extended to the configured widths
  func_t                  in_func;
  logic [SB-1:0]          in_from;
  logic [SB-1:0]          in_next;
  logic [15:0]            in_evt_ext;
  logic [15:0]            in_eid_ext;
  logic [EB-1:0]          in_evt;
  logic [EB-1:0]          in_eid;

  assign in_func    = func_t'(in_tuser);
  assign in_from    = in_tdata[SB-1:0];
  assign in_next    = in_tdata[14 +: SB];
  assign in_evt_ext = {8'b0, in_tdata[13:6]};
  assign in_eid_ext = {8'b0, in_tdata[27:20]};
  assign in_evt     = in_evt_ext[EB-1:0];
  assign in_eid     = in_eid_ext[EB-1:0];

  // Entry fields of the word read back
  logic [SB-1:0]          ent_src;
  logic [EB-1:0]          ent_evt;
  logic [SB-1:0]          ent_dst;

  assign ent_src = rd_data[ENT_W-1 -: SB];
  assign ent_evt = rd_data[SB +: EB];
  assign ent_dst = rd_data[SB-1:0];

  logic                   out_free;
  logic                   src_hit;
  logic                   evt_hit;
  logic [STATE_FIELD_W-1:0] ps_field;
  logic [STATE_FIELD_W-1:0] init_field;
  logic [15:0]            pend_ext;
  logic [15:0]            fin_ext;

  assign in_tready  = (sq_r == SQ_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign src_hit    = rdv_r && (ent_src == ps_r);
  assign evt_hit    = src_hit && (ent_evt == eid_r);
  assign ps_field   = STATE_FIELD_W'(ps_r);
  assign init_field = STATE_FIELD_W'(init_r[SB-1:0]);
  assign pend_ext   = 16'(pend_r);
  assign fin_ext    = 16'(fin_evt_r);

  fsme_edge_mem #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // Sequence requests, scan the table and load results
  always_comb begin
    sq_nxt        = sq_r;
    ps_nxt        = ps_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    rdv_nxt       = rdv_r;
    list_nxt      = list_r;
    eid_nxt       = eid_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    fin_sts_nxt   = fin_sts_r;
    fin_evt_nxt   = fin_evt_r;
    fin_nv_nxt    = fin_nv_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = {in_from, in_evt, in_next};
    rd_en         = 1'b0;

    out_valid_nxt = out_valid_r && !out_tready;
    out_sts_nxt   = out_sts_r;
    out_state_nxt = out_state_r;
    out_fin_nxt   = out_fin_r;
    out_ifin_nxt  = out_ifin_r;
    out_evt_nxt   = out_evt_r;
    out_nv_nxt    = out_nv_r;
    out_last_nxt  = out_last_r;

    case (sq_r)
      SQ_IDLE: begin
        if (in_tvalid) begin
          fin_sts_nxt = STS_OK;
          fin_evt_nxt = '0;
          fin_nv_nxt  = 1'b0;
          case (in_func)
            FN_ADD: begin
              sq_nxt = SQ_FIN;
              if (cnt_r < CW'(TABLE_DEPTH)) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                fin_sts_nxt = STS_FULL;
              end
            end
            FN_CLEAR: begin
              sq_nxt  = SQ_FIN;
              cnt_nxt = '0;
              ps_nxt  = init_r[SB-1:0];
            end
            default: begin
              // event or list: start a scan from the oldest edge
              sq_nxt     = SQ_SCAN;
              list_nxt   = (in_func == FN_LIST);
              eid_nxt    = in_eid;
              addr_nxt   = '0;
              rdv_nxt    = 1'b0;
              pend_v_nxt = 1'b0;
            end
          endcase
        end
      end

      SQ_SCAN: begin
        if (!list_r && evt_hit) begin
          // first matching edge: take it and stop
          ps_nxt      = ent_dst;
          fin_sts_nxt = STS_OK;
          fin_evt_nxt = '0;
          fin_nv_nxt  = 1'b0;
          rdv_nxt     = 1'b0;
          sq_nxt      = SQ_FIN;
        end else if (list_r && src_hit && pend_v_r && !out_free) begin
          // hold the scan until the older listed event can go out
        end else if (!rdv_r && (addr_r == cnt_r)) begin
          // every entry checked: load the closing result
          sq_nxt = SQ_FIN;
          if (list_r) begin
            fin_sts_nxt = STS_OK;
            fin_evt_nxt = pend_v_r ? pend_r : '0;
            fin_nv_nxt  = pend_v_r;
          end else begin
            fin_sts_nxt = STS_NO_MATCH;
            fin_evt_nxt = '0;
            fin_nv_nxt  = 1'b0;
          end
        end else begin
          // pass on the older listed event and keep the new one back
          if (list_r && src_hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_sts_nxt   = STS_OK;
              out_state_nxt = ps_field;
              out_fin_nxt   = mask_r[ps_field];
              out_ifin_nxt  = mask_r[init_field];
              out_evt_nxt   = pend_ext[EVENT_FIELD_W-1:0];
              out_nv_nxt    = 1'b1;
              out_last_nxt  = 1'b0;
            end
            pend_nxt   = ent_evt;
            pend_v_nxt = 1'b1;
          end
          // advance the read address
          if (addr_r != cnt_r) begin
            rd_en    = 1'b1;
            addr_nxt = addr_r + 1'b1;
            rdv_nxt  = 1'b1;
          end else begin
            rdv_nxt  = 1'b0;
          end
        end
      end

      SQ_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = fin_sts_r;
          out_state_nxt = ps_field;
          out_fin_nxt   = mask_r[ps_field];
          out_ifin_nxt  = mask_r[init_field];
          out_evt_nxt   = fin_ext[EVENT_FIELD_W-1:0];
          out_nv_nxt    = fin_nv_r;
          out_last_nxt  = 1'b1;
          sq_nxt        = SQ_IDLE;
        end
      end

      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      ps_r        <= '0;
      cnt_r       <= '0;
      addr_r      <= '0;
      rdv_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_r        <= sq_nxt;
      ps_r        <= ps_nxt;
      cnt_r       <= cnt_nxt;
      addr_r      <= addr_nxt;
      rdv_r       <= rdv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    list_r      <= list_nxt;
    eid_r       <= eid_nxt;
    pend_r      <= pend_nxt;
    fin_sts_r   <= fin_sts_nxt;
    fin_evt_r   <= fin_evt_nxt;
    fin_nv_r    <= fin_nv_nxt;
    out_sts_r   <= out_sts_nxt;
    out_state_r <= out_state_nxt;
    out_fin_r   <= out_fin_nxt;
    out_ifin_r  <= out_ifin_nxt;
    out_evt_r   <= out_evt_nxt;
    out_nv_r    <= out_nv_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
      mask_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INIT_STATE: init_r <= cfg_wdata[STATE_FIELD_W-1:0];
        REG_FINAL_MASK: mask_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_evt_r, out_ifin_r, out_fin_r, out_state_r};
  assign out_tuser  = {out_nv_r, out_sts_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: design/fsme_edge_mem.sv
// Edge table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fsme_edge_mem #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write an appended edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; hold data when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
